// ----- rtl/tun_pkg.sv -----
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Widths, payload structs and per-cell transaction structs shared by the
// triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

  // Field widths of the transactions.
  localparam int unsigned CoordWidth     = 16;
  localparam int unsigned NormalFracBits = 14;
  localparam int unsigned OutWidth       = 16;

  // Derived internal widths.
  localparam int unsigned EdgeWidth  = CoordWidth + 1;
  localparam int unsigned ProdWidth  = 2 * EdgeWidth;
  localparam int unsigned CrossWidth = ProdWidth + 1;
  localparam int unsigned MagWidth   = ProdWidth;
  localparam int unsigned SumWidth   = 2 * MagWidth;
  localparam int unsigned RootWidth  = SumWidth / 2;
  localparam int unsigned QuotWidth  = NormalFracBits + 1;

  // Input transaction: the three vertices.
  typedef struct packed {
    logic signed [CoordWidth-1:0] ax;
    logic signed [CoordWidth-1:0] ay;
    logic signed [CoordWidth-1:0] az;
    logic signed [CoordWidth-1:0] bx;
    logic signed [CoordWidth-1:0] by;
    logic signed [CoordWidth-1:0] bz;
    logic signed [CoordWidth-1:0] cx;
    logic signed [CoordWidth-1:0] cy;
    logic signed [CoordWidth-1:0] cz;
  } tun_in_t;

  // Output transaction: unit normal in Q1.14 and the degenerate flag.
  typedef struct packed {
    logic signed [OutWidth-1:0] nx;
    logic signed [OutWidth-1:0] ny;
    logic signed [OutWidth-1:0] nz;
    logic                       degenerate;
  } tun_out_t;

  // Square root cell contents.
  typedef struct packed {
    logic                           valid;
    logic [SumWidth-1:0]            rad;
    logic [RootWidth+1:0]           rem;
    logic [RootWidth-1:0]           root;
    logic [2:0][MagWidth-1:0]       mag;
    logic [2:0]                     sign;
    logic                           deg;
  } tun_sq_t;

  // Divider cell contents, three lanes sharing one divisor.
  typedef struct packed {
    logic                           valid;
    logic [RootWidth-1:0]           len;
    logic [2:0][RootWidth:0]        rem;
    logic [2:0][QuotWidth-1:0]      quot;
    logic [2:0]                     sign;
    logic                           deg;
  } tun_dv_t;

endpackage

// ----- rtl/triangle_unit_normal_core.sv -----
// Pipeline: 5 setup stages, 34 square root cells, 15 divider cells and 1 output
// register between the input transaction and the result.
// Throughput: one triangle per cycle; the whole pipeline holds while a
// result waits at the output and out_ready_i is low.
// Reset: rst_ni clears all valid bits asynchronously; data is not reset.
// ----------------------------------------------------------------------------
// Triangle unit normal core
// Edge, cross product, squared length, a chain of square root cells and a
// chain of divider cells giving the Q1.14 unit normal.
// ----------------------------------------------------------------------------
module triangle_unit_normal_core import tun_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tun_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tun_out_t out_o
);

  logic en;

  logic signed [CoordWidth-1:0] va [3];
  logic signed [CoordWidth-1:0] vb [3];
  logic signed [CoordWidth-1:0] vc [3];

  logic                        v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [EdgeWidth-1:0] e1_q [3];
  logic signed [EdgeWidth-1:0] e2_q [3];
  logic signed [ProdWidth-1:0] prod_q [6];
  logic signed [CrossWidth-1:0] cr [3];
  logic [2:0][MagWidth-1:0]    mag3_q, mag4_q, mag5_q;
  logic [2:0]                  sgn3_q, sgn4_q, sgn5_q;
  logic                        deg3_q, deg4_q, deg5_q;
  logic [SumWidth-1:0]         sq_q [3];
  logic [SumWidth-1:0]         sum_q;

  tun_sq_t  sq_chain [RootWidth+1];
  tun_dv_t  dv_chain [QuotWidth+1];
  tun_out_t res_d;
  tun_out_t res_q;
  logic     res_valid_q;
  logic [OutWidth-1:0] qmag [3];
  logic [OutWidth-1:0] comp [3];

  // The pipeline moves whenever the output register is free or being taken.
  assign en         = !res_valid_q || out_ready_i;
  assign in_ready_o = en;

  assign va[0] = in_i.ax;
  assign va[1] = in_i.ay;
  assign va[2] = in_i.az;
  assign vb[0] = in_i.bx;
  assign vb[1] = in_i.by;
  assign vb[2] = in_i.bz;
  assign vc[0] = in_i.cx;
  assign vc[1] = in_i.cy;
  assign vc[2] = in_i.cz;

  // Valid bits of the setup stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Cross product components, the differences of the registered products.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = {prod_q[2*i][ProdWidth-1], prod_q[2*i]}
            - {prod_q[2*i+1][ProdWidth-1], prod_q[2*i+1]};
    end
  end

  // Setup stages: edges, products, cross product, squares, sum.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= {vb[i][CoordWidth-1], vb[i]} - {va[i][CoordWidth-1], va[i]};
        e2_q[i] <= {vc[i][CoordWidth-1], vc[i]} - {va[i][CoordWidth-1], va[i]};
      end
      prod_q[0] <= e1_q[1] * e2_q[2];
      prod_q[1] <= e1_q[2] * e2_q[1];
      prod_q[2] <= e1_q[2] * e2_q[0];
      prod_q[3] <= e1_q[0] * e2_q[2];
      prod_q[4] <= e1_q[0] * e2_q[1];
      prod_q[5] <= e1_q[1] * e2_q[0];
      for (int i = 0; i < 3; i++) begin
        sgn3_q[i] <= cr[i][CrossWidth-1];
        mag3_q[i] <= MagWidth'(cr[i][CrossWidth-1] ? -cr[i] : cr[i]);
        sq_q[i]   <= SumWidth'(mag3_q[i]) * SumWidth'(mag3_q[i]);
      end
      deg3_q <= (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
      mag4_q <= mag3_q;
      sgn4_q <= sgn3_q;
      deg4_q <= deg3_q;
      sum_q  <= sq_q[0] + sq_q[1] + sq_q[2];
      mag5_q <= mag4_q;
      sgn5_q <= sgn4_q;
      deg5_q <= deg4_q;
    end
  end

  // Square root chain, one root bit per cell.
  always_comb begin
    sq_chain[0].valid = v5_q;
    sq_chain[0].rad   = sum_q;
    sq_chain[0].rem   = '0;
    sq_chain[0].root  = '0;
    sq_chain[0].mag   = mag5_q;
    sq_chain[0].sign  = sgn5_q;
    sq_chain[0].deg   = deg5_q;
  end

  for (genvar k = 0; k < RootWidth; k++) begin : g_sqrt
    tun_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (sq_chain[k]),
      .cell_o (sq_chain[k+1])
    );
  end

  // Divider chain, one quotient bit per cell, starting at weight 2^F.
  always_comb begin
    dv_chain[0].valid = sq_chain[RootWidth].valid;
    dv_chain[0].len   = sq_chain[RootWidth].root;
    dv_chain[0].quot  = '0;
    dv_chain[0].sign  = sq_chain[RootWidth].sign;
    dv_chain[0].deg   = sq_chain[RootWidth].deg;
    for (int i = 0; i < 3; i++) begin
      dv_chain[0].rem[i] = (RootWidth+1)'(sq_chain[RootWidth].mag[i]);
    end
  end

  for (genvar k = 0; k < QuotWidth; k++) begin : g_div
    tun_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (dv_chain[k]),
      .cell_o (dv_chain[k+1])
    );
  end

  // Apply signs; a degenerate triangle gives a zero vector.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qmag[i] = OutWidth'(dv_chain[QuotWidth].quot[i]);
      comp[i] = dv_chain[QuotWidth].deg ? '0
              : (dv_chain[QuotWidth].sign[i] ? -qmag[i] : qmag[i]);
    end
    res_d.nx         = comp[0];
    res_d.ny         = comp[1];
    res_d.nz         = comp[2];
    res_d.degenerate = dv_chain[QuotWidth].deg;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (en) begin
      res_valid_q <= dv_chain[QuotWidth].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_o       = res_q;

`ifndef ASSERT_OFF
  // A degenerate result carries a zero vector.
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.degenerate |-> out_o.nx == '0 && out_o.ny == '0 && out_o.nz == '0)
    else $error("degenerate result with non-zero normal");

  // The x component never exceeds one in magnitude in Q1.14.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $signed(out_o.nx) <= $signed(OutWidth'(1 << NormalFracBits))
                 && $signed(out_o.nx) >= -$signed(OutWidth'(1 << NormalFracBits)))
    else $error("normal component out of range");

  // A stall freezes the register of the first square root cell.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(sq_chain[1]))
    else $error("pipeline moved during stall");
`endif

endmodule

// ----- rtl/tun_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Square root cell
// Resolves one bit of the integer square root and registers the result.
// ----------------------------------------------------------------------------
module tun_sqrt_cell import tun_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  tun_sq_t cell_i,
  output tun_sq_t cell_o
);

  // The valid flag is the top field of the cell struct.
  localparam int unsigned PayWidth = $bits(tun_sq_t) - 1;

  logic [RootWidth+1:0] rem_sh;
  logic [RootWidth+1:0] trial;
  logic                 take;
  tun_sq_t              cell_d;
  logic                 valid_q;
  logic [PayWidth-1:0]  pay_q;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    rem_sh = {cell_i.rem[RootWidth-1:0], cell_i.rad[SumWidth-1 -: 2]};
    trial  = {cell_i.root, 2'b01};
    take   = (rem_sh >= trial);
    cell_d      = cell_i;
    cell_d.rad  = {cell_i.rad[SumWidth-3:0], 2'b00};
    cell_d.rem  = take ? (rem_sh - trial) : rem_sh;
    cell_d.root = {cell_i.root[RootWidth-2:0], take};
  end

  // Valid bit is reset; the payload is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= cell_d[PayWidth-1:0];
    end
  end

  assign cell_o = {valid_q, pay_q};

endmodule

// ----- rtl/tun_div_cell.sv -----
// ----------------------------------------------------------------------------
// Divider cell
// Resolves one quotient bit in each of the three component lanes.
// ----------------------------------------------------------------------------
module tun_div_cell import tun_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  tun_dv_t cell_i,
  output tun_dv_t cell_o
);

  // The valid flag is the top field of the cell struct.
  localparam int unsigned PayWidth = $bits(tun_dv_t) - 1;

  logic [RootWidth:0]  nrem;
  logic                ge;
  tun_dv_t             cell_d;
  logic                valid_q;
  logic [PayWidth-1:0] pay_q;

  // Restoring division step, lanes are independent.
  always_comb begin
    cell_d = cell_i;
    nrem   = '0;
    ge     = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ge   = (cell_i.rem[i] >= {1'b0, cell_i.len});
      nrem = ge ? (cell_i.rem[i] - {1'b0, cell_i.len}) : cell_i.rem[i];
      cell_d.rem[i]  = {nrem[RootWidth-1:0], 1'b0};
      cell_d.quot[i] = {cell_i.quot[i][QuotWidth-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= cell_d[PayWidth-1:0];
    end
  end

  assign cell_o = {valid_q, pay_q};

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Triangle unit normal core testbench
// Drives triangles through the valid/ready input, predicts each unit normal
// in the testbench, and compares every result transaction in order. Both
// sides idle at random; one phase holds the output off for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import tun_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  tun_in_t  in_i;
  logic     out_valid_o;
  logic     out_ready_i;
  tun_out_t out_o;

  tun_out_t normal_q[$];
  int       fail_cnt;
  bit       hold_off;
  int       hold_len;

  triangle_unit_normal_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .in_i(in_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Truncated quotient of a magnitude scaled to Q1.14 by the length, clamped.
  function automatic logic [15:0] scale_comp(logic signed [63:0] comp, logic [63:0] len);
    logic [127:0] m;
    logic [127:0] q;
    logic [15:0]  r;
    m = (comp < 0) ? 128'(-comp) : 128'(comp);
    q = (m << NormalFracBits) / len;
    if (q > (128'd1 << NormalFracBits)) q = 128'd1 << NormalFracBits;
    r = q[15:0];
    if (comp < 0) r = -r;
    return r;
  endfunction

  // Predicted unit normal of one triangle.
  function automatic tun_out_t face_normal(tun_in_t t);
    logic signed [63:0] e1x, e1y, e1z, e2x, e2y, e2z, px, py, pz;
    logic [127:0] s;
    logic [63:0]  root;
    logic [63:0]  trial;
    tun_out_t     r;
    e1x = 64'(t.bx) - 64'(t.ax); e1y = 64'(t.by) - 64'(t.ay); e1z = 64'(t.bz) - 64'(t.az);
    e2x = 64'(t.cx) - 64'(t.ax); e2y = 64'(t.cy) - 64'(t.ay); e2z = 64'(t.cz) - 64'(t.az);
    px = e1y * e2z - e1z * e2y;
    py = e1z * e2x - e1x * e2z;
    pz = e1x * e2y - e1y * e2x;
    r = '0;
    if (px == 0 && py == 0 && pz == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    // Squares can exceed 63 bits, so they are formed at full width.
    s = 128'(px) * 128'(px) + 128'(py) * 128'(py) + 128'(pz) * 128'(pz);
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (128'(trial) * 128'(trial) <= s) root = trial;
    end
    r.nx = scale_comp(px, root);
    r.ny = scale_comp(py, root);
    r.nz = scale_comp(pz, root);
    return r;
  endfunction

  // Random gap, mostly short with an occasional long one.
  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one triangle and wait until the transaction is accepted. Valid is
  // left high afterwards so that a following triangle can go back to back.
  task automatic send_triangle(tun_in_t t, bit idle);
    int g;
    g = idle ? rand_gap() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_i       <= t;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    normal_q.push_back(face_normal(t));
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 7)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tun_in_t rand_triangle();
    tun_in_t t;
    t = tun_in_t'($bits(tun_in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    case ($urandom_range(0, 9))
      0: begin
        t.bx = t.ax; t.by = t.ay; t.bz = t.az;
      end
      1: begin
        // Collinear: c coincides with b.
        t.cx = t.bx; t.cy = t.by; t.cz = t.bz;
      end
      2: begin
        t.ax = rand_coord(); t.ay = rand_coord(); t.az = rand_coord();
        t.bx = rand_coord(); t.by = rand_coord(); t.bz = rand_coord();
        t.cx = rand_coord(); t.cy = rand_coord(); t.cz = rand_coord();
      end
      3: begin
        t.bx = t.ax + 16'($urandom_range(0, 3)); t.by = t.ay + 16'($urandom_range(0, 3));
        t.bz = t.az; t.cx = t.ax; t.cy = t.ay + 16'($urandom_range(0, 3));
        t.cz = t.az + 16'($urandom_range(0, 3));
      end
      default: ;
    endcase
    return t;
  endfunction

  // Stop offering and wait until every expected result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (normal_q.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  // Extremes, degenerate cases and small axis-aligned triangles.
  task automatic test_directed();
    tun_in_t t;
    t = '0; send_triangle(t, 0);
    t = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
          16'h8000, 16'h7FFF, 16'h8000}; send_triangle(t, 0);
    t = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
          16'h7FFF, 16'h8000, 16'h7FFF}; send_triangle(t, 0);
    t = '{16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0};
    send_triangle(t, 0);
    t = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0};
    send_triangle(t, 0);
    t = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0};
    send_triangle(t, 0);
    t = '{16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd2, 16'd3};
    send_triangle(t, 0);
    t = '{16'd1, 16'd1, 16'd1, 16'd2, 16'd2, 16'd2, 16'd3, 16'd3, 16'd3};
    send_triangle(t, 0);
    t = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
          16'h8000, 16'h8000, 16'h8000}; send_triangle(t, 0);
    t = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
          16'h8000, 16'h8000, 16'h7FFF}; send_triangle(t, 0);
    t = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0F0F,
          16'hF0F0, 16'h3333, 16'hCCCC}; send_triangle(t, 0);
    t = '{16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5};
    send_triangle(t, 0);
    wait_drained();
  endtask

  // Random triangles with idling on the input side.
  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_triangle(rand_triangle(), 1);
  endtask

  // The output is held off while triangles keep arriving, filling the pipe.
  task automatic test_backpressure();
    hold_len = 300;
    hold_off = 1'b1;
    for (int i = 0; i < 100; i++) send_triangle(rand_triangle(), 0);
    wait_drained();
  endtask

  // Output ready with random stalls, or held low during a hold-off.
  initial begin
    int g;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (hold_len) @(negedge clk_i);
        hold_off = 1'b0;
      end
      g = rand_gap();
      if (g == 0 || $urandom_range(0, 3) == 0) out_ready_i <= 1'b1;
      else begin
        out_ready_i <= 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end
    end
  end

  // Compare each result transaction with the oldest prediction.
  initial begin
    tun_out_t exp_n;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (normal_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, out_o);
          fail_cnt++;
        end else begin
          exp_n = normal_q.pop_front();
          if (out_o.nx !== exp_n.nx)
            $display("%0t: nx expected %0d actual %0d", $realtime, exp_n.nx, out_o.nx);
          if (out_o.ny !== exp_n.ny)
            $display("%0t: ny expected %0d actual %0d", $realtime, exp_n.ny, out_o.ny);
          if (out_o.nz !== exp_n.nz)
            $display("%0t: nz expected %0d actual %0d", $realtime, exp_n.nz, out_o.nz);
          if (out_o.degenerate !== exp_n.degenerate)
            $display("%0t: degenerate expected %b actual %b", $realtime,
                     exp_n.degenerate, out_o.degenerate);
          if (out_o !== exp_n) fail_cnt++;
        end
      end
    end
  end

  // Time limit.
  initial begin
    #5ms;
    $display("FAIL triangle_unit_normal_core");
    $finish;
  end

  // Test sequence.
  initial begin
    fail_cnt   = 0;
    hold_off   = 1'b0;
    hold_len   = 0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_i       = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(400);
    // Sender pauses until every result is back.
    wait_drained();
    test_backpressure();
    test_random(440);
    wait_drained();
    if (fail_cnt == 0 && normal_q.size() == 0) $display("PASS triangle_unit_normal_core");
    else $display("FAIL triangle_unit_normal_core");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/tun_pkg.sv
rtl/tun_sqrt_cell.sv
rtl/tun_div_cell.sv
rtl/triangle_unit_normal_core.sv
tb/tb_top.sv
